[sv/tss_pkg.sv]
// Package for the C subset token scanner: word types, scanner state, mode and
// token kind codes, character constants and the keyword tables.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tss_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int VALUE_WIDTH  = 32;
    localparam int ACC_WIDTH    = VALUE_WIDTH - 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;
    localparam logic [ACC_WIDTH-1:0]    VAL_MAX = '1;

    // Scanner modes.
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_KWPART = 3'd1;
    localparam logic [2:0] M_IDENT  = 3'd2;
    localparam logic [2:0] M_KWDONE = 3'd3;
    localparam logic [2:0] M_OP1    = 3'd4;
    localparam logic [2:0] M_NUM    = 3'd5;
    localparam logic [2:0] M_ERROR  = 3'd6;
    localparam logic [2:0] M_OP2    = 3'd7;

    // Token kinds.
    localparam logic [2:0] K_WORD   = 3'd0;
    localparam logic [2:0] K_IDENT  = 3'd1;
    localparam logic [2:0] K_NUMBER = 3'd2;
    localparam logic [2:0] K_EOF    = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;

    // Characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_Z = "z";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_W     = "w";
    localparam logic [7:0] CH_E     = "e";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_I     = "i";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_LPAR  = "(";
    localparam logic [7:0] CH_RPAR  = ")";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_BANG  = "!";

    // Keyword candidates.
    localparam logic [1:0] KW_WHILE = 2'd0;
    localparam logic [1:0] KW_ELSE  = 2'd1;
    localparam logic [1:0] KW_FOR   = 2'd2;
    localparam logic [1:0] KW_IF    = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       text_end;
    } char_word_t;

    typedef struct packed {
        logic [2:0]              token_kind;
        logic [OFFSET_WIDTH-1:0] token_start;
        logic [OFFSET_WIDTH-1:0] token_length;
        logic [ACC_WIDTH-1:0]    number_value;
        logic                    value_saturated;
        logic                    last_token;
    } token_word_t;

    typedef struct packed {
        logic [2:0]              scan_mode;
        logic [1:0]              keyword_candidate;
        logic [7:0]              pending_operator;
        logic [OFFSET_WIDTH-1:0] token_begin;
        logic [OFFSET_WIDTH-1:0] token_count;
        logic [OFFSET_WIDTH-1:0] position;
        logic [ACC_WIDTH-1:0]    number_accumulator;
        logic                    overflow_seen;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]  count;
        token_word_t word0;
        token_word_t word1;
    } push_t;

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            KW_WHILE: len = 3'd5;
            KW_ELSE:  len = 3'd4;
            KW_FOR:   len = 3'd3;
            KW_IF:    len = 3'd2;
            default:  len = 3'd2;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [39:0] txt;
        logic [39:0] shifted;
        unique case (k)
            KW_WHILE: txt = "while";
            KW_ELSE:  txt = {"else", CH_NUL};
            KW_FOR:   txt = {"for", CH_NUL, CH_NUL};
            KW_IF:    txt = {"if", CH_NUL, CH_NUL, CH_NUL};
            default:  txt = '0;
        endcase
        shifted = txt << {idx, 3'b000};
        return shifted[39:32];
    endfunction

endpackage

`default_nettype wire

[sv/tss_step.sv]
// Next-state and token logic of the scanner for one character word.
// Takes the registered scanner state and gives the next state and up to two
// token words. Depends on tss_pkg.
`default_nettype none

module tss_step
    import tss_pkg::*;
(
    input  wire scan_state_t state,
    input  wire char_word_t  char_word,
    output scan_state_t      state_next,
    output push_t            push
);

    logic [7:0]              c;
    logic                    end_item;
    logic                    is_lower;
    logic                    is_digit;
    logic                    is_space;
    logic                    is_op;
    logic                    do_flush;
    logic                    do_start;
    logic                    flush_valid;
    logic                    flush_err;
    token_word_t             flush_word;
    token_word_t             eof_word;
    token_word_t             err_word;
    logic [OFFSET_WIDTH-1:0] count_sat;
    logic [3:0]              digit;
    logic [ACC_WIDTH+3:0]    acc_ext;
    logic [ACC_WIDTH+3:0]    product;
    logic [2:0]              klen;

    assign c        = char_word.ch;
    assign end_item = char_word.text_end || (c == CH_NUL);
    assign is_lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
                   || (c == CH_FF) || (c == CH_CR);
    assign is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH)
                   || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LT) || (c == CH_GT)
                   || (c == CH_EQ) || (c == CH_SEMI) || (c == CH_BANG);

    assign count_sat = (state.token_count < OFS_MAX) ? state.token_count + 1'b1
                                                     : state.token_count;
    assign digit     = 4'(c - CH_ZERO);
    assign acc_ext   = (ACC_WIDTH+4)'(state.number_accumulator);
    assign product   = (acc_ext << 3) + (acc_ext << 1) + (ACC_WIDTH+4)'(digit);
    assign klen      = kw_len(state.keyword_candidate);

    always_comb
    begin
        eof_word              = '0;
        eof_word.token_kind   = K_EOF;
        eof_word.token_start  = state.position;
        eof_word.token_length = OFFSET_WIDTH'(1);
        eof_word.last_token   = 1'b1;

        err_word              = '0;
        err_word.token_kind   = K_ERROR;
        err_word.token_start  = state.position;
        err_word.token_length = OFFSET_WIDTH'(1);
        err_word.last_token   = 1'b1;
    end

    always_comb
    begin
        flush_word              = '0;
        flush_word.token_start  = state.token_begin;
        flush_word.token_length = state.token_count;
        flush_valid             = 1'b1;
        flush_err               = 1'b0;
        unique case (state.scan_mode)
            M_KWPART, M_IDENT:
            begin
                flush_word.token_kind = K_IDENT;
            end
            M_KWDONE, M_OP2:
            begin
                flush_word.token_kind = K_WORD;
            end
            M_OP1:
            begin
                flush_word.token_length = OFFSET_WIDTH'(1);
                if (state.pending_operator == CH_BANG)
                begin
                    flush_word.token_kind = K_ERROR;
                    flush_word.last_token = 1'b1;
                    flush_err             = 1'b1;
                end
                else
                begin
                    flush_word.token_kind = K_WORD;
                end
            end
            M_NUM:
            begin
                flush_word.token_kind      = K_NUMBER;
                flush_word.number_value    = state.number_accumulator;
                flush_word.value_saturated = state.overflow_seen;
            end
            M_IDLE, M_ERROR:
            begin
                flush_valid = 1'b0;
            end
            default:
            begin
                flush_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state;
        push       = '0;
        do_flush   = 1'b0;
        do_start   = 1'b0;

        if (end_item)
        begin
            if (state.scan_mode != M_ERROR)
            begin
                if (flush_valid)
                begin
                    push.word0 = flush_word;
                    push.count = 2'd1;
                end
                if (!flush_err)
                begin
                    if (push.count == 2'd0)
                    begin
                        push.word0 = eof_word;
                    end
                    else
                    begin
                        push.word1 = eof_word;
                    end
                    push.count = push.count + 2'd1;
                end
            end
            state_next = '0;
        end
        else
        begin
            unique case (state.scan_mode)
                M_ERROR:
                begin
                end
                M_KWPART:
                begin
                    if (is_lower)
                    begin
                        if ((state.token_count < OFFSET_WIDTH'(klen))
                            && (kw_char(state.keyword_candidate, state.token_count[2:0]) == c))
                        begin
                            state_next.token_count = state.token_count + 1'b1;
                            if (state.token_count + 1'b1 == OFFSET_WIDTH'(klen))
                            begin
                                state_next.scan_mode = M_KWDONE;
                            end
                        end
                        else
                        begin
                            state_next.token_count = count_sat;
                            state_next.scan_mode   = M_IDENT;
                        end
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_lower)
                    begin
                        state_next.token_count = count_sat;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit)
                    begin
                        if (state.overflow_seen || (product > (ACC_WIDTH+4)'(VAL_MAX)))
                        begin
                            state_next.number_accumulator = VAL_MAX;
                            state_next.overflow_seen      = 1'b1;
                        end
                        else
                        begin
                            state_next.number_accumulator = product[ACC_WIDTH-1:0];
                        end
                        state_next.token_count = count_sat;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_OP1:
                begin
                    if ((c == CH_EQ) && ((state.pending_operator == CH_LT)
                        || (state.pending_operator == CH_GT)
                        || (state.pending_operator == CH_EQ)
                        || (state.pending_operator == CH_BANG)))
                    begin
                        state_next.token_count = OFFSET_WIDTH'(2);
                        state_next.scan_mode   = M_OP2;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_start = !flush_err;
                    end
                end
                M_KWDONE, M_OP2:
                begin
                    do_flush = 1'b1;
                    do_start = 1'b1;
                end
                M_IDLE:
                begin
                    do_start = 1'b1;
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            if (do_flush)
            begin
                if (flush_valid)
                begin
                    push.word0 = flush_word;
                    push.count = 2'd1;
                end
                state_next.scan_mode = flush_err ? M_ERROR : M_IDLE;
            end

            if (do_start && !is_space)
            begin
                state_next.token_begin = state.position;
                state_next.token_count = OFFSET_WIDTH'(1);
                if (is_lower)
                begin
                    if (c == CH_W || c == CH_E || c == CH_F || c == CH_I)
                    begin
                        priority case (1'b1)
                            (c == CH_W): state_next.keyword_candidate = KW_WHILE;
                            (c == CH_E): state_next.keyword_candidate = KW_ELSE;
                            (c == CH_F): state_next.keyword_candidate = KW_FOR;
                            default:     state_next.keyword_candidate = KW_IF;
                        endcase
                        state_next.scan_mode = M_KWPART;
                    end
                    else
                    begin
                        state_next.scan_mode = M_IDENT;
                    end
                end
                else if (is_digit)
                begin
                    state_next.number_accumulator = ACC_WIDTH'(digit);
                    state_next.overflow_seen      = 1'b0;
                    state_next.scan_mode          = M_NUM;
                end
                else if (is_op)
                begin
                    state_next.pending_operator = c;
                    state_next.scan_mode        = M_OP1;
                end
                else
                begin
                    if (push.count == 2'd0)
                    begin
                        push.word0 = err_word;
                    end
                    else
                    begin
                        push.word1 = err_word;
                    end
                    push.count           = push.count + 2'd1;
                    state_next.scan_mode = M_ERROR;
                end
            end

            state_next.position = state.position + 1'b1;
        end
    end

endmodule

`default_nettype wire

[sv/tss_fifo.sv]
// Small output queue of token words: takes up to two words a cycle, gives one when popped.
// Reports whether room remains for two more. Depends on tss_pkg.
`default_nettype none

module tss_fifo
    import tss_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire push_t  push,
    input  wire         pop,
    output logic        not_empty,
    output logic        room_for_two,
    output token_word_t head
);

    token_word_t          entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic [FIFO_AW-1:0]   wr_ptr_plus;
    logic                 do_pop;

    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign head         = entry_reg[rd_ptr_reg];
    assign do_pop       = pop && not_empty;
    assign wr_ptr_plus  = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.word0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push.word1;
        end
    end

endmodule

`default_nettype wire

[sv/c_subset_token_scanner.sv]
// Flow: a character word is taken into an input register and scanned from there
// once the token queue has room; the token words it completes go into the queue.
// Throughput: one character word per cycle, but input stalls while the four-entry
// token queue holds three or more; one token word out per cycle unless token_stall.
// Reset: rst_n clears the scanner state and the queue at once; no clearing pass.
// Top level of the token scanner; depends on tss_pkg, tss_step and tss_fifo.
`default_nettype none

module c_subset_token_scanner
    import tss_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         char_valid,
    output logic        char_stall,
    input  wire char_word_t  char_word,
    output logic        token_valid,
    input  wire         token_stall,
    output token_word_t token_word
);

    logic        in_valid_reg;
    logic        in_valid_next;
    char_word_t  in_word_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t step_state;
    push_t       step_push;
    push_t       fifo_push;
    logic        room_for_two;
    logic        process;
    logic        accept;

    assign process    = in_valid_reg && room_for_two;
    assign char_stall = in_valid_reg && !room_for_two;
    assign accept     = char_valid && !char_stall;

    tss_step u_step (
        .state      (state_reg),
        .char_word  (in_word_reg),
        .state_next (step_state),
        .push       (step_push)
    );

    always_comb
    begin
        state_next    = process ? step_state : state_reg;
        fifo_push     = process ? step_push : '0;
        in_valid_next = accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= char_word;
        end
    end

    tss_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fifo_push),
        .pop          (!token_stall),
        .not_empty    (token_valid),
        .room_for_two (room_for_two),
        .head         (token_word)
    );

endmodule

`default_nettype wire

[sv/tss_checker.sv]
// Port-level checks on the token scanner's input and output words, bound to the top level.
// Depends on tss_pkg and c_subset_token_scanner.
`default_nettype none

module tss_checker
    import tss_pkg::*;
(
    input wire         clk,
    input wire         rst_n,
    input wire         char_valid,
    input wire         char_stall,
    input wire char_word_t  char_word,
    input wire         token_valid,
    input wire         token_stall,
    input wire token_word_t token_word
);

    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_word))
        else $error("Stalled token word was not held.");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_word))
        else $error("Stalled character word was not held.");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> token_word.last_token
            == (token_word.token_kind == K_EOF || token_word.token_kind == K_ERROR))
        else $error("Last flag does not match the token kind.");

    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_word.token_kind != K_NUMBER
            |-> token_word.number_value == '0 && !token_word.value_saturated)
        else $error("Non-number token carries a value.");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_word.token_kind == K_EOF || token_word.token_kind == K_ERROR)
            |-> token_word.token_length == OFFSET_WIDTH'(1))
        else $error("End or error token with length other than one.");

endmodule

bind c_subset_token_scanner tss_checker u_tss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_word   (char_word),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_word  (token_word)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for the C subset token scanner: directed table of characters,
// then random texts and a fixed text; each token checked against a predictor here.
// Depends on tss_pkg and c_subset_token_scanner.
`default_nettype none

module tb_top;
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_WORDS = 1500;

    typedef struct {
        logic [7:0]  ch;
        logic        te;
        int          typed;
        token_word_t t0;
        token_word_t t1;
    } char_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    char_word_t  char_word = '0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    token_word_t token_word;

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit hold_request = 1'b0;
    int fails = 0;
    int live_words = 0;
    int quiet_cycles = 0;

    token_word_t due_tokens[$];
    token_word_t step_tokens[$];
    char_row_t   directed_rows[$];

    string      keyword_words [4] = '{"while", "else", "for", "if"};
    logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    logic [7:0] single_ops [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR,
                                    CH_RPAR, CH_LT, CH_GT, CH_EQ, CH_SEMI};
    logic [7:0] pair_heads [4] = '{CH_EQ, CH_BANG, CH_GT, CH_LT};

    logic [2:0]              lex_mode;
    logic [1:0]              lex_kw;
    logic [7:0]              lex_op;
    logic [OFFSET_WIDTH-1:0] lex_begin;
    logic [OFFSET_WIDTH-1:0] lex_len;
    logic [OFFSET_WIDTH-1:0] lex_pos;
    logic [ACC_WIDTH-1:0]    lex_acc;
    logic                    lex_ovf;

    c_subset_token_scanner DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic token_word_t tok(input logic [2:0] k, input int s, input int l,
                                        input int v, input logic sat, input logic last);
        token_word_t w;
        w.token_kind      = k;
        w.token_start     = s[OFFSET_WIDTH-1:0];
        w.token_length    = l[OFFSET_WIDTH-1:0];
        w.number_value    = v[ACC_WIDTH-1:0];
        w.value_saturated = sat;
        w.last_token      = last;
        return w;
    endfunction

    function automatic string show(input token_word_t w);
        return $sformatf("kind=%0d start=%0d length=%0d value=%0d sat=%0b last=%0b",
                         w.token_kind, w.token_start, w.token_length, w.number_value,
                         w.value_saturated, w.last_token);
    endfunction

    function automatic bit same_token(input token_word_t a, input token_word_t b);
        return a.token_kind === b.token_kind && a.token_start === b.token_start &&
               a.token_length === b.token_length && a.number_value === b.number_value &&
               a.value_saturated === b.value_saturated && a.last_token === b.last_token;
    endfunction

    function automatic void note_mismatch(input string what, input token_word_t want,
                                          input token_word_t got);
        fails++;
        if (fails <= 10)
            $display("%s: expected %s, got %s", what, show(want), show(got));
    endfunction

    function automatic void reset_lexer();
        lex_mode  = M_IDLE;
        lex_kw    = KW_WHILE;
        lex_op    = CH_NUL;
        lex_begin = '0;
        lex_len   = '0;
        lex_pos   = '0;
        lex_acc   = '0;
        lex_ovf   = 1'b0;
    endfunction

    function automatic void emit_token(input logic [2:0] k, input logic [OFFSET_WIDTH-1:0] s,
                                       input logic [OFFSET_WIDTH-1:0] l,
                                       input logic [ACC_WIDTH-1:0] v, input logic sat,
                                       input logic last);
        token_word_t w;
        w.token_kind      = k;
        w.token_start     = s;
        w.token_length    = l;
        w.number_value    = v;
        w.value_saturated = sat;
        w.last_token      = last;
        due_tokens.push_back(w);
        step_tokens.push_back(w);
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return c >= CH_LOW_A && c <= CH_LOW_Z;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void grow_length();
        if (lex_len != OFS_MAX)
            lex_len = lex_len + 1'b1;
    endfunction

    function automatic bit flush_token();
        case (lex_mode)
            M_KWPART, M_IDENT: emit_token(K_IDENT, lex_begin, lex_len, '0, 1'b0, 1'b0);
            M_KWDONE, M_OP2:   emit_token(K_WORD, lex_begin, lex_len, '0, 1'b0, 1'b0);
            M_OP1:
            begin
                if (lex_op == CH_BANG)
                begin
                    emit_token(K_ERROR, lex_begin, OFFSET_WIDTH'(1), '0, 1'b0, 1'b1);
                    lex_mode = M_ERROR;
                    return 1'b1;
                end
                emit_token(K_WORD, lex_begin, OFFSET_WIDTH'(1), '0, 1'b0, 1'b0);
            end
            M_NUM: emit_token(K_NUMBER, lex_begin, lex_len, lex_acc, lex_ovf, 1'b0);
            default: ;
        endcase
        lex_mode = M_IDLE;
        return 1'b0;
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR})
            return;
        lex_begin = lex_pos;
        lex_len   = OFFSET_WIDTH'(1);
        if (is_letter(c))
        begin
            lex_mode = M_KWPART;
            case (c)
                CH_W:    lex_kw = KW_WHILE;
                CH_E:    lex_kw = KW_ELSE;
                CH_F:    lex_kw = KW_FOR;
                CH_I:    lex_kw = KW_IF;
                default: lex_mode = M_IDENT;
            endcase
        end
        else if (is_digit(c))
        begin
            lex_acc  = ACC_WIDTH'(c - CH_ZERO);
            lex_ovf  = 1'b0;
            lex_mode = M_NUM;
        end
        else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR,
                           CH_LT, CH_GT, CH_EQ, CH_SEMI, CH_BANG})
        begin
            lex_op   = c;
            lex_mode = M_OP1;
        end
        else
        begin
            emit_token(K_ERROR, lex_pos, OFFSET_WIDTH'(1), '0, 1'b0, 1'b1);
            lex_mode = M_ERROR;
        end
    endfunction

    function automatic void scan_char(input char_word_t w);
        logic [7:0]        c;
        longint unsigned   d;
        longint unsigned   top;
        c   = w.ch;
        top = VAL_MAX;
        step_tokens.delete();
        if (w.text_end || c == CH_NUL)
        begin
            if (lex_mode != M_ERROR)
            begin
                if (!flush_token())
                    emit_token(K_EOF, lex_pos, OFFSET_WIDTH'(1), '0, 1'b0, 1'b1);
            end
            reset_lexer();
            return;
        end
        case (lex_mode)
            M_ERROR: ;
            M_KWPART:
            begin
                if (is_letter(c))
                begin
                    if (lex_len < keyword_words[lex_kw].len() &&
                        keyword_words[lex_kw][lex_len] == c)
                    begin
                        lex_len = lex_len + 1'b1;
                        if (lex_len == keyword_words[lex_kw].len())
                            lex_mode = M_KWDONE;
                    end
                    else
                    begin
                        grow_length();
                        lex_mode = M_IDENT;
                    end
                end
                else
                begin
                    void'(flush_token());
                    open_token(c);
                end
            end
            M_IDENT:
            begin
                if (is_letter(c))
                    grow_length();
                else
                begin
                    void'(flush_token());
                    open_token(c);
                end
            end
            M_NUM:
            begin
                if (is_digit(c))
                begin
                    d = c - CH_ZERO;
                    if (lex_ovf || lex_acc > (top - d) / 10)
                    begin
                        lex_acc = VAL_MAX;
                        lex_ovf = 1'b1;
                    end
                    else
                        lex_acc = ACC_WIDTH'(lex_acc * 10 + d);
                    grow_length();
                end
                else
                begin
                    void'(flush_token());
                    open_token(c);
                end
            end
            M_OP1:
            begin
                if (c == CH_EQ && lex_op inside {CH_LT, CH_GT, CH_EQ, CH_BANG})
                begin
                    lex_len  = OFFSET_WIDTH'(2);
                    lex_mode = M_OP2;
                end
                else if (!flush_token())
                    open_token(c);
            end
            M_KWDONE, M_OP2:
            begin
                void'(flush_token());
                open_token(c);
            end
            default:
            begin
                lex_mode = M_IDLE;
                open_token(c);
            end
        endcase
        lex_pos = lex_pos + 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic te);
        char_word_t w;
        w.ch       = c;
        w.text_end = te;
        while (tx_gaps && $urandom_range(99) < 22)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_word  <= w;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        if (lex_mode != M_ERROR)
            live_words++;
        scan_char(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        char_valid <= 1'b0;
        while (due_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_text();
        string kw;
        int    n;
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: send_text(keyword_words[$urandom_range(0, 3)]);
                4, 5:
                begin
                    kw = keyword_words[$urandom_range(0, 3)];
                    n  = $urandom_range(1, kw.len() - 1);
                    for (int i = 0; i < n; i++)
                        send_char(kw[i], 1'b0);
                end
                6, 7, 8:
                    repeat ($urandom_range(1, 6))
                        send_char(8'(CH_LOW_A + $urandom_range(0, 25)), 1'b0);
                9, 10, 11:
                begin
                    case ($urandom_range(0, 7))
                        0: send_text("2147483647");
                        1: send_text("2147483648");
                        2: repeat ($urandom_range(10, 14))
                               send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                        default: repeat ($urandom_range(1, 4))
                                     send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                    endcase
                end
                12, 13, 14: send_char(single_ops[$urandom_range(0, 9)], 1'b0);
                15, 16:
                begin
                    send_char(pair_heads[$urandom_range(0, 3)], 1'b0);
                    send_char(CH_EQ, 1'b0);
                end
                17: send_char(blanks[$urandom_range(0, 5)], 1'b0);
                18: send_char(CH_BANG, 1'b0);
                default: send_char(8'($urandom_range(0, 255)), 1'b0);
            endcase
            if ($urandom_range(0, 1) == 1)
                send_char(blanks[$urandom_range(0, 5)], 1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            send_char(CH_NUL, 1'b0);
        else
            send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Receiver: random stalls, or one long hold-off when the sender asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                token_stall  <= 1'b1;
                hold_request <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                token_stall <= rx_gaps && ($urandom_range(99) < 22);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
        begin
            if (due_tokens.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("token word with none expected: %s", show(token_word));
            end
            else if (!same_token(due_tokens[0], token_word))
                note_mismatch("token word", due_tokens.pop_front(), token_word);
            else
                void'(due_tokens.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (token_valid && !token_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        char_row_t row;
        int        text_no;
        reset_lexer();

        directed_rows.push_back('{8'h40, 1'b0, 1, tok(K_ERROR, 0, 1, 0, 0, 1), '0});
        directed_rows.push_back('{CH_LOW_A, 1'b0, 0, '0, '0});
        directed_rows.push_back('{8'hFF, 1'b1, 0, '0, '0});
        directed_rows.push_back('{CH_W, 1'b0, 0, '0, '0});
        directed_rows.push_back('{8'h68, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_I, 1'b0, 0, '0, '0});
        directed_rows.push_back('{8'h6C, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_E, 1'b0, 0, '0, '0});
        directed_rows.push_back('{8'h78, 1'b0, 1, tok(K_WORD, 0, 5, 0, 0, 0), '0});
        directed_rows.push_back('{CH_BANG, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_EQ, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_F, 1'b0, 1, tok(K_WORD, 6, 2, 0, 0, 0), '0});
        directed_rows.push_back('{8'h6F, 1'b0, 0, '0, '0});
        directed_rows.push_back('{8'h37, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_BANG, 1'b0, 1, tok(K_NUMBER, 10, 1, 7, 0, 0), '0});
        directed_rows.push_back('{CH_SPACE, 1'b0, 1, tok(K_ERROR, 11, 1, 0, 0, 1), '0});
        directed_rows.push_back('{CH_NUL, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_I, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_F, 1'b0, 0, '0, '0});
        directed_rows.push_back('{CH_NUL, 1'b0, 2, tok(K_WORD, 0, 2, 0, 0, 0),
                                  tok(K_EOF, 2, 1, 0, 0, 1)});
        directed_rows.push_back('{CH_GT, 1'b0, 0, '0, '0});
        directed_rows.push_back('{8'h5A, 1'b1, 2, tok(K_WORD, 0, 1, 0, 0, 0),
                                  tok(K_EOF, 1, 1, 0, 0, 1)});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_char(row.ch, row.te);
            if (row.typed > 0)
            begin
                if (step_tokens.size() != row.typed)
                    note_mismatch("table row token count", row.t0, '0);
                else
                begin
                    if (!same_token(row.t0, step_tokens[0]))
                        note_mismatch("table row", row.t0, step_tokens[0]);
                    if (row.typed > 1 && !same_token(row.t1, step_tokens[1]))
                        note_mismatch("table row", row.t1, step_tokens[1]);
                end
            end
        end
        wait_drained();

        live_words = 0;
        text_no    = 0;
        while (live_words < RANDOM_WORDS)
        begin
            tx_gaps = !(text_no >= 30 && text_no < 70);
            rx_gaps <= !(text_no >= 30 && text_no < 70);
            if (text_no == 15)
                hold_request <= 1'b1;
            if (text_no == 90)
                wait_drained();
            random_text();
            text_no++;
        end

        send_text(" ab 3>=4 fo 77 ");
        send_char(CH_NUL, 1'b1);

        char_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        fails += due_tokens.size();
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
